// ===== design/ffilt_pkg.sv =====
// Shared types and constants for the frequency threshold filter.
// Used by ffilt_cell and frequency_threshold_filter_core; no dependencies.
`default_nettype none
package ffilt_pkg;

	localparam int VALUE_W = 32;
	localparam int CNT_W   = 7;

	// Commands from the sequencer to every cell of the row
	typedef struct packed {
		logic wr;     // write the cell addressed by the load index
		logic probe;  // compare against the circulating copy, then rotate it
		logic shift;  // rotate value, valid and count one cell down the ring
		logic clear;  // drop every entry at the end of a run
	} cell_ctrl_t;

	// What one cell hands to its neighbor on a rotate
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               valid;
		logic [CNT_W-1:0]   cnt;
	} cell_data_t;

endpackage
`default_nettype wire

// ===== design/frequency_threshold_filter_core.sv =====
// Top level of the frequency threshold filter: sequencer, ring of cells,
// output register and APB register. Depends on ffilt_pkg and ffilt_cell.
//
//   channel  | dir | handshake                 | payload
//   s_axis   | in  | s_tvalid / s_tready       | s_tdata value_in, s_tlast is_last_in
//   m_axis   | out | m_tvalid / m_tready       | m_tdata value_out, m_tlast is_last_out,
//            |     |                           | m_tuser kept_total/empty/overflow
//   apb      | in  | psel, penable, pready     | paddr, pwdata, prdata (min_count)
//
// Loading accepts one item per cycle. The closing item starts three passes
// around the ring of MAX_ITEMS cells: count, tally and emit, the emit pass
// stalling on the output; an empty run emits one empty result instead of the
// emit pass. Input is held off during the passes.
// Reset clears control state and sets min_count to 1.
`default_nettype none
module frequency_threshold_filter_core #(
	parameter int MAX_ITEMS = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	// stream in
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] value_in
	input  wire         s_tlast,
	// stream out
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [31:0] value_out
	output logic        m_tlast,
	output logic [8:0]  m_tuser,   // [6:0] kept_total, [7] empty_flag, [8] overflow_flag
	// configuration
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ffilt_pkg::*;

	localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_ITEMS - 1);
	localparam logic [CNT_W-1:0] CAPACITY  = CNT_W'(MAX_ITEMS);

	localparam logic [2:0] ADDR_MIN_COUNT = 3'd0;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_COUNT = 2'd1;
	localparam logic [1:0] ST_TALLY = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] stored_q;
	logic             dropped_q;
	logic [IDX_W-1:0] step_q;
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] emitted_q;
	logic [CNT_W-1:0] min_count_q;

	logic             out_valid_q;
	logic [31:0]      out_value_q;
	logic [CNT_W-1:0] out_total_q;
	logic             out_last_q;
	logic             out_empty_q;
	logic             out_ovf_q;

	cell_ctrl_t       ctrl;
	cell_data_t       cdata [MAX_ITEMS];
	logic [VALUE_W-1:0] crot [MAX_ITEMS];
	logic             crot_valid [MAX_ITEMS];
	logic             ckept [MAX_ITEMS];

	logic in_xfer;
	logic room;
	logic out_free;
	logic load_out;
	logic finish;
	logic cfg_wr;

	// ring of cells, each fed by its upper neighbor
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		ffilt_cell #(.INDEX(i)) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.wr_idx       (stored_q),
			.wr_value     (s_tdata),
			.min_count    (min_count_q),
			.nbr_data     (cdata[(i + 1) % MAX_ITEMS]),
			.nbr_rot      (crot[(i + 1) % MAX_ITEMS]),
			.nbr_rot_valid(crot_valid[(i + 1) % MAX_ITEMS]),
			.data         (cdata[i]),
			.rot          (crot[i]),
			.rot_valid    (crot_valid[i]),
			.kept         (ckept[i])
		);
	end

	assign s_tready = (state_q == ST_LOAD);
	assign in_xfer  = s_tvalid && s_tready;
	assign room     = (stored_q < CAPACITY);
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		ctrl     = '0;
		load_out = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				ctrl.wr = in_xfer && room;
			end
			ST_COUNT: begin
				ctrl.probe = 1'b1;
			end
			ST_TALLY: begin
				ctrl.shift = 1'b1;
			end
			ST_EMIT: begin
				if (total_q == '0) begin
					load_out = out_free;
					finish   = out_free;
				end else begin
					ctrl.shift = out_free;
					load_out   = out_free && ckept[0];
					finish     = out_free && (step_q == LAST_STEP);
				end
			end
			default: ;
		endcase
		ctrl.clear = finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			stored_q  <= '0;
			dropped_q <= 1'b0;
			step_q    <= '0;
			total_q   <= '0;
			emitted_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (room) begin
							stored_q <= stored_q + 1'b1;
						end else begin
							dropped_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_COUNT;
							step_q  <= '0;
						end
					end
				end
				ST_COUNT: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						state_q <= ST_TALLY;
						step_q  <= '0;
						total_q <= '0;
					end
				end
				ST_TALLY: begin
					step_q  <= step_q + 1'b1;
					total_q <= total_q + CNT_W'(ckept[0]);
					if (step_q == LAST_STEP) begin
						state_q   <= ST_EMIT;
						step_q    <= '0;
						emitted_q <= '0;
					end
				end
				ST_EMIT: begin
					if (ctrl.shift) begin
						step_q <= step_q + 1'b1;
					end
					if (load_out) begin
						emitted_q <= emitted_q + 1'b1;
					end
					if (finish) begin
						state_q   <= ST_LOAD;
						stored_q  <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// output register; a finished result waits here while loading resumes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ovf_q <= dropped_q;
			if (total_q == '0) begin
				out_value_q <= '0;
				out_total_q <= '0;
				out_last_q  <= 1'b1;
				out_empty_q <= 1'b1;
			end else begin
				out_value_q <= cdata[0].value;
				out_total_q <= total_q;
				out_last_q  <= (emitted_q + 1'b1 == total_q);
				out_empty_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = {out_ovf_q, out_empty_q, out_total_q};

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_MIN_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_count_q <= CNT_W'(1);
		end else if (cfg_wr) begin
			min_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_MIN_COUNT) begin
			prdata = {{(32 - CNT_W){1'b0}}, min_count_q};
		end
	end

`ifndef SYNTHESIS
	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CAPACITY)
		else $error("stored count beyond capacity");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (emitted_q <= total_q))
		else $error("more results emitted than kept");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[7]) |-> (m_tlast && m_tuser[6:0] == '0 && m_tdata == '0))
		else $error("empty result malformed");

	a_close_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_tlast) |=> (state_q == ST_COUNT && step_q == '0))
		else $error("closing item did not start the count pass");
`endif

endmodule
`default_nettype wire

// ===== design/ffilt_cell.sv =====
// One cell of the filter row: holds one list entry, its occurrence count
// and a circulating probe copy. Depends on ffilt_pkg.
`default_nettype none
module ffilt_cell #(
	parameter int INDEX = 0
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire ffilt_pkg::cell_ctrl_t   ctrl,
	input  wire [ffilt_pkg::CNT_W-1:0]   wr_idx,
	input  wire [ffilt_pkg::VALUE_W-1:0] wr_value,
	input  wire [ffilt_pkg::CNT_W-1:0]   min_count,
	input  wire ffilt_pkg::cell_data_t   nbr_data,
	input  wire [ffilt_pkg::VALUE_W-1:0] nbr_rot,
	input  wire                          nbr_rot_valid,
	output ffilt_pkg::cell_data_t        data,
	output logic [ffilt_pkg::VALUE_W-1:0] rot,
	output logic                         rot_valid,
	output logic                         kept
);
	import ffilt_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic               valid_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [VALUE_W-1:0] rot_q;
	logic               rot_valid_q;
	logic               sel;
	logic               match;

	assign sel   = ctrl.wr && (wr_idx == CNT_W'(INDEX));
	assign match = valid_q && rot_valid_q && (rot_q == value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			rot_valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q     <= 1'b0;
			rot_valid_q <= 1'b0;
		end else if (sel) begin
			valid_q     <= 1'b1;
			rot_valid_q <= 1'b1;
		end else if (ctrl.shift) begin
			valid_q     <= nbr_data.valid;
		end else if (ctrl.probe) begin
			rot_valid_q <= nbr_rot_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			value_q <= wr_value;
			rot_q   <= wr_value;
			cnt_q   <= '0;
		end else if (ctrl.shift) begin
			value_q <= nbr_data.value;
			cnt_q   <= nbr_data.cnt;
		end else if (ctrl.probe) begin
			rot_q   <= nbr_rot;
			cnt_q   <= cnt_q + CNT_W'(match);
		end
	end

	assign data      = '{value: value_q, valid: valid_q, cnt: cnt_q};
	assign rot       = rot_q;
	assign rot_valid = rot_valid_q;
	assign kept      = valid_q && (cnt_q >= min_count);

endmodule
`default_nettype wire

// ===== tb/frequency_threshold_filter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for frequency_threshold_filter_core: streams lists in,
// predicts the kept values and checks every output transfer. Needs only the RTL.
module frequency_threshold_filter_core_tb;

	localparam int MAX_ITEMS     = 64;
	localparam int MIN_COUNT_IDX = 0;
	localparam int SPARE_IDX     = 1;
	localparam int DRAIN_CYCLES  = 3 * MAX_ITEMS + 16;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} list_item_t;

	typedef struct packed {
		logic [31:0] value;
		logic [6:0]  kept;
		logic        last;
		logic        empty;
		logic        ovf;
	} filt_result_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic [8:0]  m_tuser;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	frequency_threshold_filter_core #(.MAX_ITEMS(MAX_ITEMS)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	list_item_t   pending_items[$];
	filt_result_t pending_results[$];
	logic [31:0]  list_mem [MAX_ITEMS];
	int unsigned  list_len     = 0;
	bit           list_dropped = 1'b0;
	logic [6:0]   min_thresh   = 7'd1;
	int unsigned  send_idle_pct = 0;
	int unsigned  recv_idle_pct = 0;
	int unsigned  err_count     = 0;
	int unsigned  cycle_count   = 0;
	logic         in_fire       = 1'b0;

	function automatic int unsigned count_matches(logic [31:0] v);
		int unsigned c;
		c = 0;
		for (int j = 0; j < list_len; j++)
			if (list_mem[j] == v)
				c++;
		return c;
	endfunction

	// Store one list element; on the closing element queue the kept values, or one empty result if none is kept.
	task automatic absorb_value(logic [31:0] v, bit last);
		int unsigned kept;
		int unsigned k;
		filt_result_t r;
		kept = 0;
		k = 0;
		if (list_len < MAX_ITEMS) begin
			list_mem[list_len] = v;
			list_len++;
		end else begin
			list_dropped = 1'b1;
		end
		if (!last)
			return;
		for (int i = 0; i < list_len; i++)
			if (count_matches(list_mem[i]) >= min_thresh)
				kept++;
		if (kept == 0) begin
			r = '{value: '0, kept: '0, last: 1'b1, empty: 1'b1, ovf: list_dropped};
			pending_results.push_back(r);
		end else begin
			for (int i = 0; i < list_len; i++) begin
				if (count_matches(list_mem[i]) >= min_thresh) begin
					r.value = list_mem[i];
					r.kept  = 7'(kept);
					r.last  = (k + 1 == kept);
					r.empty = 1'b0;
					r.ovf   = list_dropped;
					pending_results.push_back(r);
					k++;
				end
			end
		end
		list_len = 0;
		list_dropped = 1'b0;
	endtask

	// Input side: hold an offered item until its transfer, then maybe idle.
	always @(negedge clk) begin : drive_in
		list_item_t nxt;
		logic       vld;
		vld = s_tvalid;
		nxt = '{value: s_tdata, last: s_tlast};
		if (!s_tvalid || in_fire) begin
			vld = 1'b0;
			if (arst_n && pending_items.size() != 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = pending_items.pop_front();
				vld = 1'b1;
			end
		end
		s_tvalid <= vld;
		s_tdata  <= nxt.value;
		s_tlast  <= nxt.last;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : watch
		filt_result_t exp_r;
		in_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			absorb_value(s_tdata, s_tlast);
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer: value_out %h", m_tdata);
				err_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata !== exp_r.value) begin
					$error("value_out: expected %h, got %h", exp_r.value, m_tdata);
					err_count++;
				end
				if (m_tuser[6:0] !== exp_r.kept) begin
					$error("kept_total: expected %0d, got %0d", exp_r.kept, m_tuser[6:0]);
					err_count++;
				end
				if (m_tlast !== exp_r.last) begin
					$error("is_last_out: expected %b, got %b", exp_r.last, m_tlast);
					err_count++;
				end
				if (m_tuser[7] !== exp_r.empty) begin
					$error("empty_flag: expected %b, got %b", exp_r.empty, m_tuser[7]);
					err_count++;
				end
				if (m_tuser[8] !== exp_r.ovf) begin
					$error("overflow_flag: expected %b, got %b", exp_r.ovf, m_tuser[8]);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic apb_write(int idx, logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(idx * 4);
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == MIN_COUNT_IDX)
			min_thresh = data[6:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_min_count;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= 3'(MIN_COUNT_IDX * 4);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(min_thresh)) begin
			$error("min_count: expected %0d, got %0d", min_thresh, prdata);
			err_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_min_count(int unsigned val);
		apb_write(MIN_COUNT_IDX, 32'(val));
		check_min_count();
	endtask

	// Block until every item has gone in and every result has come out.
	task automatic settle;
		while (pending_items.size() != 0 || s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_list(logic [31:0] vals[$]);
		foreach (vals[i])
			pending_items.push_back('{value: vals[i], last: (i == vals.size() - 1)});
	endtask

	function automatic logic [31:0] pick_word();
		logic [31:0] edges[4];
		edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
		if ($urandom_range(0, 3) == 0)
			return edges[$urandom_range(0, 3)];
		return $urandom();
	endfunction

	// Random lists drawn from a small pool so values repeat; some pure noise.
	task automatic fill_random(int unsigned target);
		logic [31:0] pool[4];
		logic [31:0] vals[$];
		int unsigned len, pool_n, made;
		bit noise;
		made = 0;
		while (made < target) begin
			vals.delete();
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(60, 70);
			else
				len = $urandom_range(1, 12);
			pool_n = $urandom_range(1, 4);
			noise = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < pool_n; i++)
				pool[i] = pick_word();
			for (int i = 0; i < len; i++)
				vals.push_back(noise ? $urandom() : pool[$urandom_range(0, pool_n - 1)]);
			push_list(vals);
			made += len;
		end
	endtask

	initial begin
		int unsigned thresholds[6];
		logic [31:0] vals[$];
		logic [31:0] rep;
		thresholds = '{2, 0, 1, 3, 64, 4};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lists, starting from the reset threshold of one
		send_idle_pct = 34;
		recv_idle_pct = 73;
		check_min_count();
		push_list('{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h7fff_ffff});
		push_list('{32'h0000_0001});
		settle();
		set_min_count(2);
		push_list('{32'd5, 32'd5, 32'd7, 32'd5});
		push_list('{32'd1, 32'd2, 32'd3});
		push_list('{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555});
		settle();
		apb_write(SPARE_IDX, 32'd0);
		check_min_count();
		set_min_count(0);
		push_list('{32'h7fff_ffff, 32'h8000_0000});
		settle();
		set_min_count(64);
		push_list('{32'd9, 32'd9, 32'd9});
		settle();

		for (int p = 0; p < 6; p++) begin
			send_idle_pct = (p < 2) ? 34 : (p < 4) ? 73 : 0;
			recv_idle_pct = (p < 2) ? 73 : (p < 4) ? 34 : 0;
			set_min_count(thresholds[p]);
			if (thresholds[p] == 64) begin
				// full store of one value, then drops, the closing item among them
				vals.delete();
				rep = pick_word();
				for (int i = 0; i < 66; i++)
					vals.push_back(rep);
				push_list(vals);
			end
			fill_random(18);
			settle();
		end

		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
design/ffilt_pkg.sv
design/ffilt_cell.sv
design/frequency_threshold_filter_core.sv
tb/frequency_threshold_filter_core_tb.sv
